/* rtl/fpa_pkg.sv */
package fpa_pkg;

  // Operand and result word width
  localparam int unsigned DATA_W = 32;

  // Command codes carried on in_tuser
  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_GT      = 4'd4,
    CMD_LT      = 4'd5,
    CMD_GE      = 4'd6,
    CMD_LE      = 4'd7,
    CMD_EQ      = 4'd8,
    CMD_NE      = 4'd9,
    CMD_MIN     = 4'd10,
    CMD_MAX     = 4'd11,
    CMD_INC     = 4'd12,
    CMD_DEC     = 4'd13,
    CMD_TOINT   = 4'd14,
    CMD_FROMINT = 4'd15
  } cmd_t;

endpackage

/* rtl/fixed_point_alu.sv */
// Signed 32-bit fixed-point ALU with FRACTION_BITS fraction bits.
//
// Input channel (in_*): one item per handshake; in_tuser carries the command,
// in_tdata carries operand_a (bits 31:0) and operand_b (bits 63:32).
// Output channel (out_*): exactly one item per input item, in order;
// out_tdata carries result_value (31:0) and compare_true (32), upper bits
// zero; out_tuser carries status (1 = divide by zero).
//
// The pipeline is an input register, a setup register, a restoring divider
// with one register stage per quotient bit (32 + FRACTION_BITS quotient bits),
// and an output register. Every command travels the same path, so ordering
// is kept. One item is accepted every cycle while the output is not stalled.
//
// Reset (rst_n low, synchronous) drops every item in flight and clears
// out_tvalid. When the receiver holds out_tready low while out_tvalid is
// high, the whole pipeline freezes and in_tready goes low in the same cycle;
// nothing is lost or repeated, and the output item holds steady.
module fixed_point_alu #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  in_tuser,   // command [3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value [31:0], compare_true [32], zero [39:33]
  output logic        out_tuser   // status [0]
);

  localparam int unsigned DW = fpa_pkg::DATA_W;
  localparam int unsigned NQ = DW + FRACTION_BITS;  // quotient bits = divider steps

  // Global advance: the pipeline moves unless the output item is stalled
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Input register stage
  logic                 v1_r;
  fpa_pkg::cmd_t        cmd1_r;
  logic signed [DW-1:0] a1_r;
  logic signed [DW-1:0] b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= fpa_pkg::cmd_t'(in_tuser);
      a1_r   <= in_tdata[DW-1:0];
      b1_r   <= in_tdata[2*DW-1:DW];
    end
  end

  // Decode stage: simple results, product, divider setup
  logic [DW-1:0] res0;
  logic          cmp0;
  logic [DW-1:0] mag_a;
  logic [DW-1:0] mag_b;

  always_comb begin
    res0 = '0;
    cmp0 = 1'b0;
    case (cmd1_r)
      fpa_pkg::CMD_ADD:     res0 = a1_r + b1_r;
      fpa_pkg::CMD_SUB:     res0 = a1_r - b1_r;
      fpa_pkg::CMD_GT:      cmp0 = a1_r > b1_r;
      fpa_pkg::CMD_LT:      cmp0 = a1_r < b1_r;
      fpa_pkg::CMD_GE:      cmp0 = a1_r >= b1_r;
      fpa_pkg::CMD_LE:      cmp0 = a1_r <= b1_r;
      fpa_pkg::CMD_EQ:      cmp0 = a1_r == b1_r;
      fpa_pkg::CMD_NE:      cmp0 = a1_r != b1_r;
      fpa_pkg::CMD_MIN:     res0 = (a1_r < b1_r) ? a1_r : b1_r;
      fpa_pkg::CMD_MAX:     res0 = (a1_r > b1_r) ? a1_r : b1_r;
      fpa_pkg::CMD_INC:     res0 = a1_r + DW'(1);
      fpa_pkg::CMD_DEC:     res0 = a1_r - DW'(1);
      fpa_pkg::CMD_TOINT:   res0 = a1_r >>> FRACTION_BITS;
      fpa_pkg::CMD_FROMINT: res0 = a1_r << FRACTION_BITS;
      default:              res0 = '0;
    endcase
    mag_a = a1_r[DW-1] ? DW'(-a1_r) : a1_r;
    mag_b = b1_r[DW-1] ? DW'(-b1_r) : b1_r;
  end

  // Divider chain: stage 0 is the setup register, stage k+1 follows step k
  logic                   sv_r   [NQ+1];
  logic [DW-1:0]          res_r  [NQ+1];
  logic                   cmp_r  [NQ+1];
  logic                   dz_r   [NQ+1];
  logic                   div_r  [NQ+1];
  logic                   neg_r  [NQ+1];
  logic [DW-1:0]          rem_r  [NQ+1];
  logic [NQ-1:0]          num_r  [NQ+1];
  logic [DW-1:0]          den_r  [NQ+1];
  logic                   mul0_r;
  logic signed [2*DW-1:0] prod_r;

  logic                   sv_nxt  [NQ+1];
  logic [DW-1:0]          res_nxt [NQ+1];
  logic                   cmp_nxt [NQ+1];
  logic                   dz_nxt  [NQ+1];
  logic                   div_nxt [NQ+1];
  logic                   neg_nxt [NQ+1];
  logic [DW-1:0]          rem_nxt [NQ+1];
  logic [NQ-1:0]          num_nxt [NQ+1];
  logic [DW-1:0]          den_nxt [NQ+1];
  logic signed [2*DW-1:0] prod_sh;

  always_comb begin
    logic [DW:0] r_sh;
    logic        ge;
    prod_sh = prod_r >>> FRACTION_BITS;

    // Set up stage 0 from the input register
    sv_nxt[0]  = v1_r;
    res_nxt[0] = res0;
    cmp_nxt[0] = cmp0;
    div_nxt[0] = (cmd1_r == fpa_pkg::CMD_DIV);
    dz_nxt[0]  = (cmd1_r == fpa_pkg::CMD_DIV) && (b1_r == '0);
    neg_nxt[0] = a1_r[DW-1] ^ b1_r[DW-1];
    rem_nxt[0] = '0;
    num_nxt[0] = {mag_a, {FRACTION_BITS{1'b0}}};
    den_nxt[0] = mag_b;

    // One restoring divide step per stage; other fields ride along
    for (int k = 0; k < NQ; k++) begin
      r_sh = {rem_r[k], num_r[k][NQ-1]};
      ge   = r_sh >= {1'b0, den_r[k]};
      sv_nxt[k+1]  = sv_r[k];
      res_nxt[k+1] = res_r[k];
      cmp_nxt[k+1] = cmp_r[k];
      div_nxt[k+1] = div_r[k];
      dz_nxt[k+1]  = dz_r[k];
      neg_nxt[k+1] = neg_r[k];
      rem_nxt[k+1] = ge ? DW'(r_sh - {1'b0, den_r[k]}) : r_sh[DW-1:0];
      num_nxt[k+1] = {num_r[k][NQ-2:0], ge};
      den_nxt[k+1] = den_r[k];
    end

    // Insert the scaled product after the multiplier register
    if (mul0_r) begin
      res_nxt[1] = prod_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NQ; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k <= NQ; k++) begin
        sv_r[k] <= sv_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= NQ; k++) begin
        res_r[k] <= res_nxt[k];
        cmp_r[k] <= cmp_nxt[k];
        dz_r[k]  <= dz_nxt[k];
        div_r[k] <= div_nxt[k];
        neg_r[k] <= neg_nxt[k];
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
        den_r[k] <= den_nxt[k];
      end
      mul0_r <= (cmd1_r == fpa_pkg::CMD_MUL);
      prod_r <= a1_r * b1_r;
    end
  end

  // Output register: apply quotient sign and the zero-divisor case
  logic [DW-1:0] quo;
  logic [DW-1:0] fin_res;
  logic [DW-1:0] out_res_r;
  logic          out_cmp_r;
  logic          out_st_r;

  always_comb begin
    quo = num_r[NQ][DW-1:0];
    if (dz_r[NQ]) begin
      fin_res = '0;
    end else if (div_r[NQ]) begin
      fin_res = neg_r[NQ] ? DW'(-quo) : quo;
    end else begin
      fin_res = res_r[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv_r[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= fin_res;
      out_cmp_r <= cmp_r[NQ];
      out_st_r  <= dz_r[NQ];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cmp_r, out_res_r};
  assign out_tuser  = out_st_r;

endmodule

/* rtl/fpa_checker.sv */
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // Stall at the output freezes the input side too
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline is stalled");

  // Divide by zero gives a zero result and no compare flag
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[32:0] == 33'd0)
    else $error("divide by zero item carries nonzero data");

  // Upper padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("padding bits of out_tdata are not zero");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
